// ----- rtl/core/msort_pkg.sv -----
// Shared word type and compare function for the merge sort engine.
package msort_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  function automatic logic not_greater(input word_t a, input word_t b);
    return $signed(a) <= $signed(b);
  endfunction

endpackage

// ----- rtl/core/merge_sort_engine_top.sv -----
// Top level of the stream merge sort engine with its two element memories.
//
// Usage:
//   Input stream s_axis: one signed 32-bit element per transaction in tdata;
//   tlast marks the final element of a set and starts the sort. Up to
//   MAX_ITEMS elements are kept; later ones are dropped and flagged.
//   Output stream m_axis: the set in ascending order, stable for ties, one
//   element per transaction; tlast on the final element, tuser set on every
//   element of a set that lost elements to overflow.
//   Loading takes one cycle per element. After tlast the sort runs
//   ceil(log2 n) passes over two one-port-write, two-port-read memories;
//   each pass sets up every merged run pair in S_RUN and merges it in
//   S_MERGE. The emit then streams one element per cycle while the
//   receiver does not stall, each through a registered memory read.
//   s_axis_tready is low from the tlast transaction until the final result
//   sits in the output register; the next set may load while it waits.
//   A stalled receiver holds the output register and pauses the memory reads.
//   Reset (rst, synchronous) empties the set and drops any pending output;
//   memory contents are not cleared and need no clearing pass.
module merge_sort_engine_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  msort_pkg::word_t s_axis_tdata,   // [31:0] value_in
  input  logic             s_axis_tlast,   // last_in
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output msort_pkg::word_t m_axis_tdata,   // [31:0] value_out
  output logic             m_axis_tlast,   // last_out
  output logic             m_axis_tuser    // [0] overflowed
);

  import msort_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  word_t mem_a [MAX_ITEMS];
  word_t mem_b [MAX_ITEMS];
  word_t ra0, ra1, rb0, rb1;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] width;
  logic          src_sel;
  logic [CW-1:0] lo, mid, hi;
  logic [CW-1:0] i_ptr, j_ptr, k_ptr, e_ptr;
  logic          rv;
  logic          rd_last;
  logic          out_valid;
  word_t         out_data;
  logic          out_last;
  logic          out_ovf;

  logic          in_acc;
  logic          has_room;
  logic [CW-1:0] n_new;
  logic [CW:0]   sum_mid, sum_hi, width_dbl;
  logic [CW-1:0] run_mid, run_hi;
  word_t         src0, src1, merge_data;
  logic          left_ok, right_ok, take_left;
  logic [CW-1:0] k_inc;
  logic          out_free, load_out, issue;
  logic          rd_en;
  logic [CW-1:0] raddr0, raddr1;
  logic          we_a, we_b;
  logic [CW-1:0] waddr;
  word_t         wdata;

  assign s_axis_tready = (state == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign has_room      = (count < MAX_CNT);
  assign n_new         = has_room ? count + CW'(1) : count;

  assign sum_mid   = {1'b0, lo} + {1'b0, width};
  assign sum_hi    = {1'b0, lo} + ({1'b0, width} << 1);
  assign run_mid   = (sum_mid > {1'b0, count}) ? count : sum_mid[CW-1:0];
  assign run_hi    = (sum_hi > {1'b0, count}) ? count : sum_hi[CW-1:0];
  assign width_dbl = {1'b0, width} << 1;

  assign src0       = src_sel ? rb0 : ra0;
  assign src1       = src_sel ? rb1 : ra1;
  assign left_ok    = (i_ptr < mid);
  assign right_ok   = (j_ptr < hi);
  assign take_left  = left_ok && (!right_ok || not_greater(src0, src1));
  assign merge_data = take_left ? src0 : src1;
  assign k_inc      = k_ptr + CW'(1);

  assign out_free = !out_valid || m_axis_tready;
  assign load_out = (state == S_EMIT) && rv && out_free;
  assign issue    = (state == S_EMIT) && (e_ptr < count) && (!rv || load_out);

  always_comb begin
    rd_en  = 1'b0;
    raddr0 = i_ptr;
    raddr1 = j_ptr;
    case (state)
      S_RUN: begin
        rd_en  = 1'b1;
        raddr0 = lo;
        raddr1 = run_mid;
      end
      S_MERGE: begin
        rd_en  = 1'b1;
        raddr0 = take_left ? i_ptr + CW'(1) : i_ptr;
        raddr1 = take_left ? j_ptr : j_ptr + CW'(1);
      end
      S_EMIT: begin
        rd_en  = issue;
        raddr0 = e_ptr;
        raddr1 = e_ptr;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign we_a  = (in_acc && has_room) || ((state == S_MERGE) && src_sel);
  assign we_b  = (state == S_MERGE) && !src_sel;
  assign waddr = (state == S_LOAD) ? count : k_ptr;
  assign wdata = (state == S_LOAD) ? s_axis_tdata : merge_data;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr[AW-1:0]] <= wdata;
    end
    if (rd_en) begin
      ra0 <= mem_a[raddr0[AW-1:0]];
      ra1 <= mem_a[raddr1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr[AW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rb0 <= mem_b[raddr0[AW-1:0]];
      rb1 <= mem_b[raddr1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      width   <= '0;
      src_sel <= 1'b0;
      lo      <= '0;
      mid     <= '0;
      hi      <= '0;
      i_ptr   <= '0;
      j_ptr   <= '0;
      k_ptr   <= '0;
      e_ptr   <= '0;
      rv      <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            count <= n_new;
            if (!has_room) begin
              ovf <= 1'b1;
            end
            if (s_axis_tlast) begin
              width   <= CW'(1);
              src_sel <= 1'b0;
              lo      <= '0;
              e_ptr   <= '0;
              rv      <= 1'b0;
              state   <= (n_new > CW'(1)) ? S_RUN : S_EMIT;
            end
          end
        end
        S_RUN: begin
          mid   <= run_mid;
          hi    <= run_hi;
          i_ptr <= lo;
          j_ptr <= run_mid;
          k_ptr <= lo;
          state <= S_MERGE;
        end
        S_MERGE: begin
          k_ptr <= k_inc;
          if (take_left) begin
            i_ptr <= i_ptr + CW'(1);
          end else begin
            j_ptr <= j_ptr + CW'(1);
          end
          if (k_inc == hi) begin
            if (hi == count) begin
              src_sel <= !src_sel;
              lo      <= '0;
              if (width_dbl >= {1'b0, count}) begin
                e_ptr <= '0;
                rv    <= 1'b0;
                state <= S_EMIT;
              end else begin
                width <= width_dbl[CW-1:0];
                state <= S_RUN;
              end
            end else begin
              lo    <= hi;
              state <= S_RUN;
            end
          end
        end
        S_EMIT: begin
          if (issue) begin
            e_ptr   <= e_ptr + CW'(1);
            rv      <= 1'b1;
            rd_last <= (e_ptr + CW'(1) == count);
          end else if (load_out) begin
            rv <= 1'b0;
          end
          if (load_out && rd_last) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= src_sel ? rb0 : ra0;
      out_last <= rd_last;
      out_ovf  <= ovf;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_ovf;

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("element count above capacity");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input accepted right after the final element of a set");

  a_merge_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (k_ptr < hi && i_ptr <= mid && j_ptr <= hi))
    else $error("merge pointers out of run bounds");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the stream merge sort engine: directed and random sets, sorted-order scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import msort_pkg::*;

  localparam int unsigned CAPACITY = 64;

  typedef struct packed {
    word_t value;
    logic  last;
    logic  ovf;
  } sorted_word_t;

  class sorted_set_book;
    word_t        held[$];
    bit           dropped;
    sorted_word_t due[$];
    int unsigned  failures;

    function void sort_held();
      word_t       scratch[$];
      int unsigned n, w, lo, mid, hi, i, j, k;
      n = held.size();
      scratch = held;
      for (w = 1; w < n; w = w * 2) begin
        for (lo = 0; lo < n; lo += 2 * w) begin
          mid = (lo + w > n) ? n : lo + w;
          hi = (lo + 2 * w > n) ? n : lo + 2 * w;
          i = lo;
          j = mid;
          k = lo;
          while (i < mid || j < hi) begin
            if (j >= hi || (i < mid && $signed(held[i]) <= $signed(held[j]))) begin
              scratch[k] = held[i];
              i++;
            end else begin
              scratch[k] = held[j];
              j++;
            end
            k++;
          end
        end
        held = scratch;
      end
    endfunction

    function void note_element(word_t v, bit l);
      sorted_word_t e;
      if (held.size() < CAPACITY) begin
        held.push_back(v);
      end else begin
        dropped = 1'b1;
      end
      if (l) begin
        sort_held();
        foreach (held[idx]) begin
          e.value = held[idx];
          e.last = (idx == held.size() - 1);
          e.ovf = dropped;
          due.push_back(e);
        end
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(word_t v, logic l, logic ovf);
      sorted_word_t e;
      if (due.size() == 0) begin
        $error("unexpected transaction: value_out=%0d last_out=%0b overflowed=%0b",
               $signed(v), l, ovf);
        failures++;
        return;
      end
      e = due.pop_front();
      if (e.value !== v) begin
        $error("value_out: expected %0d, actual %0d", $signed(e.value), $signed(v));
        failures++;
      end
      if (e.last !== l) begin
        $error("last_out: expected %0b, actual %0b", e.last, l);
        failures++;
      end
      if (e.ovf !== ovf) begin
        $error("overflowed: expected %0b, actual %0b", e.ovf, ovf);
        failures++;
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  s_axis_tvalid;
  logic  s_axis_tready;
  word_t s_axis_tdata;   // [31:0] value_in
  logic  s_axis_tlast;   // last_in
  logic  m_axis_tvalid;
  logic  m_axis_tready;
  word_t m_axis_tdata;   // [31:0] value_out
  logic  m_axis_tlast;   // last_out
  logic  m_axis_tuser;   // [0] overflowed

  int unsigned    send_gap_pct;
  int unsigned    take_stall_pct;
  sorted_set_book book = new;

  merge_sort_engine_top #(
    .MAX_ITEMS(CAPACITY)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic word_t draw_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3, 4: return word_t'($urandom_range(0, 8)) - 32'd4;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic push_element(word_t v, bit l);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tlast <= l;
    do @(posedge clk); while (!s_axis_tready);
    book.note_element(v, l);
  endtask

  task automatic push_set(word_t vals[$]);
    foreach (vals[idx]) push_element(vals[idx], idx == vals.size() - 1);
  endtask

  task automatic push_random_set(int unsigned count);
    word_t vals[$];
    repeat (count) vals.push_back(draw_value());
    push_set(vals);
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        book.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= take_stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    word_t       vals[$];
    int unsigned sent;
    int unsigned count;
    send_gap_pct = 0;
    take_stall_pct = 0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    vals = '{32'h8000_0000};
    push_set(vals);
    vals = '{32'h0000_0003, 32'hffff_fffd};
    push_set(vals);
    vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
             32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000};
    push_set(vals);
    vals = '{32'd5, 32'd5, 32'hffff_fffd, 32'd5, 32'hffff_fffd};
    push_set(vals);
    vals = '{32'd40, 32'd30, 32'd20, 32'd10, 32'd0};
    push_set(vals);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 0;
          take_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 55;
          take_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          take_stall_pct = 55;
        end
        default: begin
          send_gap_pct = 21;
          take_stall_pct = 21;
        end
      endcase
      sent = 0;
      while (sent < 12) begin
        count = $urandom_range(1, 12);
        push_random_set(count);
        sent += count;
      end
      case (ph)
        0: push_random_set(CAPACITY);
        2: push_random_set(CAPACITY + 1);
        3: push_random_set($urandom_range(CAPACITY + 2, CAPACITY + 6));
        default: ;
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (book.due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (book.failures == 0 && book.due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/msort_pkg.sv
rtl/core/merge_sort_engine_top.sv
tb/sv/tb_top.sv
